[rtl/core/ttsp_pkg.sv]
// Shared types, character codes and class functions of the text token splitter.
// No dependencies; used by the lexer, the result queue and the top level under rtl/core.
package ttsp_pkg;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_MINUS = 4'd2,
    M_LINE  = 4'd3,
    M_BLOCK = 4'd4,
    M_BSTAR = 4'd5,
    M_QUOTE = 4'd6,
    M_QQ    = 4'd7,
    M_WORD  = 4'd8
  } lex_mode_t;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  localparam logic [7:0] EXTRA_PUNCT_RESET = 8'd163;

  // Result queue depth; must be at least two.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] ch, logic last);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.last = last;
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
  endfunction

  function automatic logic is_fixed_punct(logic [7:0] c);
    logic hit;
    case (c)
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h2B, 8'h2D,
      8'h2A, 8'h2F, 8'h26, 8'h5E, 8'h25, 8'h24, 8'h3C, 8'h3E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[rtl/core/ttsp_in_reg.sv]
// Input register of the text token splitter: holds one request until the lexer takes it.
// Depends on nothing beyond its ports.
module ttsp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_char,
  output logic       item_end
);

  logic full;
  logic load;

  assign in_stall   = full && !take;
  assign load       = in_valid && !in_stall;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_char <= in_char;
      item_end  <= end_of_text;
    end
  end

endmodule

[rtl/core/ttsp_lexer.sv]
// Lexer step of the text token splitter: mode/held-char state, punctuation register and
// the per-byte decision that yields up to two results. Uses ttsp_pkg.
module ttsp_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                item_valid,
  input  logic [7:0]          item_char,
  input  logic                item_end,
  input  logic                room,
  output logic                fire,
  output ttsp_pkg::step_out_t step
);
  import ttsp_pkg::*;

  lex_mode_t  mode, mode_next;
  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic [7:0] extra_punct;

  logic       text_end;
  lex_mode_t  sb_mode;
  logic       sb_emit;
  logic [7:0] sb_held;
  logic       sb_hv;
  result_t    res [2];
  logic [1:0] n;

  assign fire     = item_valid && room;
  // A zero byte ends the text just like the flag.
  assign text_end = item_end || (item_char == CH_NUL);

  // What a byte does where a token could start.
  always_comb begin
    sb_mode = M_IDLE;
    sb_emit = 1'b0;
    sb_held = '0;
    sb_hv   = 1'b0;
    if (is_ws(item_char)) begin
      sb_mode = M_IDLE;
    end else if (item_char == CH_SLASH) begin
      sb_mode = M_SLASH;
    end else if (item_char == CH_QUOTE) begin
      sb_mode = M_QUOTE;
    end else if (item_char == CH_MINUS) begin
      sb_mode = M_MINUS;
    end else if (is_fixed_punct(item_char) || item_char == extra_punct) begin
      sb_emit = 1'b1;
    end else begin
      sb_held = item_char;
      sb_hv   = 1'b1;
      sb_mode = M_WORD;
    end
  end

  always_comb begin
    mode_next       = mode;
    held_char_next  = held_char;
    held_valid_next = held_valid;
    res[0]          = '0;
    res[1]          = '0;
    n               = 2'd0;
    if (text_end) begin
      case (mode)
        M_SLASH: begin
          res[n[0]] = make_result(KIND_CHAR, CH_SLASH, 1'b1);
          n = n + 2'd1;
        end
        M_MINUS: begin
          res[n[0]] = make_result(KIND_CHAR, CH_MINUS, 1'b1);
          n = n + 2'd1;
        end
        M_QUOTE, M_QQ: begin
          if (held_valid) begin
            res[n[0]] = make_result(KIND_CHAR, held_char, 1'b1);
          end else begin
            res[n[0]] = make_result(KIND_EMPTY, CH_NUL, 1'b1);
          end
          n = n + 2'd1;
        end
        M_WORD: begin
          if (held_valid) begin
            res[n[0]] = make_result(KIND_CHAR, held_char, 1'b1);
            n = n + 2'd1;
          end
        end
        default: ;
      endcase
      res[n[0]] = make_result(KIND_END, CH_NUL, 1'b0);
      n = n + 2'd1;
      mode_next       = M_IDLE;
      held_char_next  = '0;
      held_valid_next = 1'b0;
    end else begin
      case (mode)
        M_SLASH: begin
          if (item_char == CH_SLASH) begin
            mode_next = M_LINE;
          end else if (item_char == CH_STAR) begin
            mode_next = M_BSTAR;
          end else begin
            res[n[0]] = make_result(KIND_CHAR, CH_SLASH, 1'b1);
            n = n + 2'd1;
            mode_next       = sb_mode;
            held_char_next  = sb_held;
            held_valid_next = sb_hv;
            if (sb_emit) begin
              res[n[0]] = make_result(KIND_CHAR, item_char, 1'b1);
              n = n + 2'd1;
            end
          end
        end
        M_MINUS: begin
          if (is_digit(item_char)) begin
            res[n[0]] = make_result(KIND_CHAR, CH_MINUS, 1'b0);
            n = n + 2'd1;
            held_char_next  = item_char;
            held_valid_next = 1'b1;
            mode_next       = M_WORD;
          end else begin
            res[n[0]] = make_result(KIND_CHAR, CH_MINUS, 1'b1);
            n = n + 2'd1;
            mode_next       = sb_mode;
            held_char_next  = sb_held;
            held_valid_next = sb_hv;
            if (sb_emit) begin
              res[n[0]] = make_result(KIND_CHAR, item_char, 1'b1);
              n = n + 2'd1;
            end
          end
        end
        M_LINE: begin
          if (item_char == CH_NEWLINE) begin
            mode_next = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (item_char == CH_STAR) begin
            mode_next = M_BSTAR;
          end
        end
        M_BSTAR: begin
          if (item_char == CH_SLASH) begin
            mode_next = M_IDLE;
          end else if (item_char != CH_STAR) begin
            mode_next = M_BLOCK;
          end
        end
        M_QUOTE: begin
          if (item_char == CH_QUOTE) begin
            mode_next = M_QQ;
          end else begin
            if (held_valid) begin
              res[n[0]] = make_result(KIND_CHAR, held_char, 1'b0);
              n = n + 2'd1;
            end
            held_char_next  = item_char;
            held_valid_next = 1'b1;
          end
        end
        M_QQ: begin
          if (item_char == CH_QUOTE) begin
            // doubled quote: one literal quote character
            if (held_valid) begin
              res[n[0]] = make_result(KIND_CHAR, held_char, 1'b0);
              n = n + 2'd1;
            end
            held_char_next  = CH_QUOTE;
            held_valid_next = 1'b1;
            mode_next       = M_QUOTE;
          end else begin
            if (held_valid) begin
              res[n[0]] = make_result(KIND_CHAR, held_char, 1'b1);
            end else begin
              res[n[0]] = make_result(KIND_EMPTY, CH_NUL, 1'b1);
            end
            n = n + 2'd1;
            mode_next       = sb_mode;
            held_char_next  = sb_held;
            held_valid_next = sb_hv;
            if (sb_emit) begin
              res[n[0]] = make_result(KIND_CHAR, item_char, 1'b1);
              n = n + 2'd1;
            end
          end
        end
        M_WORD: begin
          if (is_ws(item_char)) begin
            if (held_valid) begin
              res[n[0]] = make_result(KIND_CHAR, held_char, 1'b1);
              n = n + 2'd1;
            end
            held_char_next  = '0;
            held_valid_next = 1'b0;
            mode_next       = M_IDLE;
          end else begin
            if (held_valid) begin
              res[n[0]] = make_result(KIND_CHAR, held_char, 1'b0);
              n = n + 2'd1;
            end
            held_char_next  = item_char;
            held_valid_next = 1'b1;
          end
        end
        default: begin
          mode_next       = sb_mode;
          held_char_next  = sb_held;
          held_valid_next = sb_hv;
          if (sb_emit) begin
            res[n[0]] = make_result(KIND_CHAR, item_char, 1'b1);
            n = n + 2'd1;
          end
        end
      endcase
    end
  end

  assign step.count  = fire ? n : 2'd0;
  assign step.first  = res[0];
  assign step.second = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      held_char  <= '0;
      held_valid <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      held_char  <= held_char_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_punct <= EXTRA_PUNCT_RESET;
    end else if (cfg_wr_en) begin
      extra_punct <= cfg_wr_data;
    end
  end

  // A held character only exists inside a word or a string.
  a_held_in_token: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (mode == M_QUOTE || mode == M_QQ || mode == M_WORD))
    else $error("held character outside a word or string");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    fire && text_end |=> mode == M_IDLE && !held_valid)
    else $error("end of text did not return to idle");

  a_end_marker_last: assert property (@(posedge clk) disable iff (rst)
    fire && text_end |-> (n == 2'd1 ? step.first.kind == KIND_END
                                    : step.second.kind == KIND_END))
    else $error("end of text without end marker as last result");

  a_comment_silent: assert property (@(posedge clk) disable iff (rst)
    fire && !text_end && (mode == M_LINE || mode == M_BLOCK || mode == M_BSTAR)
    |-> n == 2'd0)
    else $error("result emitted inside a comment");

endmodule

[rtl/core/ttsp_result_queue.sv]
// Result queue of the text token splitter: takes up to two results per step, hands
// out one per request. Uses ttsp_pkg.
module ttsp_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  ttsp_pkg::step_out_t step,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          result_kind,
  output logic [7:0]          tok_char,
  output logic                token_last
);
  import ttsp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  result_t            head;

  assign room      = count <= CNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  assign result_kind = head.kind;
  assign tok_char    = head.ch;
  assign token_last  = head.last;

  always_ff @(posedge clk) begin
    if (step.count != 2'd0) begin
      entries[wr_ptr] <= step.first;
    end
    if (step.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= step.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(step.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(step.count) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    step.count != 2'd0 |-> room)
    else $error("results pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && step.count == 2'd0 |=> count == $past(count) - CNT_W'(1))
    else $error("queue count wrong after a pop");

endmodule

[rtl/core/text_token_splitter.sv]
// Text token splitter top level: input register, lexer step and result queue.
// Depends on ttsp_pkg, ttsp_in_reg, ttsp_lexer and ttsp_result_queue.
//
// Takes one text byte per request and returns token characters one per request,
// the last character of each token flagged, plus empty-token and end-of-text markers.
// A byte accepted into the input register is decoded straight out of it; once the queue has
// room its results are registered into the result queue, which offers the first of them.
// One byte is accepted every cycle as long as the output side takes one result per cycle.
// A byte that yields two results leaves one extra result, which the four-entry result queue
// absorbs. Two results come from a pending slash or minus followed by punctuation, a closing
// quote followed by punctuation, or a flush at end of text. The lexer waits while the queue
// holds more than two results. The input stalls while a byte waits in the input register
// and the lexer does not take it.
// Because of one byte of lookahead, each word or string character comes out when the next byte
// arrives. The punctuation register may be written only while no request is in flight.
module text_token_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] tok_char,
  output logic       token_last
);
  import ttsp_pkg::*;

  logic       item_valid;
  logic [7:0] item_char;
  logic       item_end;
  logic       fire;
  logic       room;
  step_out_t  step;

  ttsp_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .take        (fire),
    .item_valid  (item_valid),
    .item_char   (item_char),
    .item_end    (item_end)
  );

  ttsp_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_char   (item_char),
    .item_end    (item_end),
    .room        (room),
    .fire        (fire),
    .step        (step)
  );

  ttsp_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tok_char    (tok_char),
    .token_last  (token_last)
  );

endmodule

[bench/tb_text_token_splitter.sv]
// Self-checking bench for text_token_splitter: directed table, then random text.
// Predicts token results from its own lexer copy; depends on ttsp_pkg and text_token_splitter.
module tb_text_token_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import ttsp_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 38;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         n_fix;  // -1: predicted, else count of typed results
    result_t    r0;
    result_t    r1;
  } text_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] tok_char;
  logic       token_last;

  // lexer copy
  lex_mode_t  lx_mode = M_IDLE;
  logic [7:0] lx_held = 8'h00;
  logic       lx_has = 1'b0;
  logic [7:0] punct_x = EXTRA_PUNCT_RESET;
  string      punct_set = "{}[]()+-*/&^%$<>";

  result_t    step_q[$];
  result_t    tok_q[$];
  text_row_t  text_q[$];
  text_row_t  cur_row;

  int  bad_count = 0;
  int  n_out = 0;
  int  quiet_cycles = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  hold_req = 1'b0;

  logic [7:0] punct_cfgs [4] = '{8'h00, 8'hFF, 8'h40, 8'h61};

  text_token_splitter DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tok_char    (tok_char),
    .token_last  (token_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t res(logic [1:0] k, logic [7:0] c, logic l);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    return r;
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic punct(logic [7:0] c);
    for (int i = 0; i < punct_set.len(); i++)
      if (punct_set[i] == c) return 1'b1;
    return c == punct_x;
  endfunction

  function automatic void put(logic [1:0] k, logic [7:0] c, logic l);
    step_q.insert(step_q.size(), res(k, c, l));
  endfunction

  function automatic void flush_hold();
    if (lx_has) put(KIND_CHAR, lx_held, 1'b1);
    lx_has  = 1'b0;
    lx_held = 8'h00;
  endfunction

  function automatic void hold_char(logic [7:0] c);
    if (lx_has) put(KIND_CHAR, lx_held, 1'b0);
    lx_held = c;
    lx_has  = 1'b1;
  endfunction

  // byte arriving where a token may begin
  function automatic void token_start(logic [7:0] c);
    lx_has  = 1'b0;
    lx_held = 8'h00;
    if (blank(c)) begin
      lx_mode = M_IDLE;
    end else if (c == CH_SLASH) begin
      lx_mode = M_SLASH;
    end else if (c == CH_QUOTE) begin
      lx_mode = M_QUOTE;
    end else if (c == CH_MINUS) begin
      lx_mode = M_MINUS;
    end else if (punct(c)) begin
      put(KIND_CHAR, c, 1'b1);
      lx_mode = M_IDLE;
    end else begin
      hold_char(c);
      lx_mode = M_WORD;
    end
  endfunction

  function automatic void close_string();
    if (lx_has) flush_hold();
    else put(KIND_EMPTY, 8'h00, 1'b1);
  endfunction

  function automatic void lex_step(logic [7:0] c, logic e);
    step_q.delete();
    if (e || c == CH_NUL) begin
      case (lx_mode)
        M_SLASH: put(KIND_CHAR, CH_SLASH, 1'b1);
        M_MINUS: put(KIND_CHAR, CH_MINUS, 1'b1);
        M_QUOTE, M_QQ: close_string();
        M_WORD: flush_hold();
        default: ;
      endcase
      put(KIND_END, 8'h00, 1'b0);
      lx_mode = M_IDLE;
      lx_held = 8'h00;
      lx_has  = 1'b0;
      return;
    end
    case (lx_mode)
      M_SLASH: begin
        if (c == CH_SLASH) lx_mode = M_LINE;
        else if (c == CH_STAR) lx_mode = M_BSTAR;
        else begin
          put(KIND_CHAR, CH_SLASH, 1'b1);
          token_start(c);
        end
      end
      M_MINUS: begin
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
          lx_has = 1'b0;
          hold_char(CH_MINUS);
          hold_char(c);
          lx_mode = M_WORD;
        end else begin
          put(KIND_CHAR, CH_MINUS, 1'b1);
          token_start(c);
        end
      end
      M_LINE: if (c == CH_NEWLINE) lx_mode = M_IDLE;
      M_BLOCK: if (c == CH_STAR) lx_mode = M_BSTAR;
      M_BSTAR: begin
        if (c == CH_SLASH) lx_mode = M_IDLE;
        else if (c != CH_STAR) lx_mode = M_BLOCK;
      end
      M_QUOTE: begin
        if (c == CH_QUOTE) lx_mode = M_QQ;
        else hold_char(c);
      end
      M_QQ: begin
        if (c == CH_QUOTE) begin
          hold_char(CH_QUOTE);
          lx_mode = M_QUOTE;
        end else begin
          close_string();
          token_start(c);
        end
      end
      M_WORD: begin
        if (blank(c)) begin
          flush_hold();
          lx_mode = M_IDLE;
        end else begin
          hold_char(c);
        end
      end
      default: token_start(c);
    endcase
  endfunction

  task automatic report_bad(string field, int got, int want_v);
    bad_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d", n_out, field, got, want_v);
  endtask

  task automatic add(logic [7:0] c, logic e);
    text_row_t row;
    row.ch    = c;
    row.eot   = e;
    row.n_fix = -1;
    row.r0    = res(KIND_CHAR, 8'h00, 1'b0);
    row.r1    = row.r0;
    text_q.insert(text_q.size(), row);
  endtask

  task automatic add_fix(logic [7:0] c, logic e, int n, result_t r0, result_t r1);
    text_row_t row;
    row.ch    = c;
    row.eot   = e;
    row.n_fix = n;
    row.r0    = r0;
    row.r1    = r1;
    text_q.insert(text_q.size(), row);
  endtask

  function automatic logic [7:0] blank_byte();
    logic [7:0] c;
    c = 8'($urandom_range(8, 13));
    return (c == 8'd8) ? CH_SPACE : c;
  endfunction

  // mostly well-formed tokens with random content, some noise and cut-off text
  task automatic gen_text(int n);
    int         start, pick, len;
    logic [7:0] c;
    start = text_q.size();
    while (text_q.size() - start < n) begin
      pick = $urandom_range(0, 19);
      if (pick <= 4) begin
        add(8'($urandom_range(0, 1) ? $urandom_range(97, 122) : $urandom_range(65, 90)), 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) add(8'($urandom_range(33, 255)), 1'b0);
        add(blank_byte(), 1'b0);
      end else if (pick <= 6) begin
        add(CH_MINUS, 1'b0);
        len = $urandom_range(1, 3);
        repeat (len) add(8'($urandom_range(48, 57)), 1'b0);
        add(blank_byte(), 1'b0);
      end else if (pick <= 8) begin
        if ($urandom_range(0, 4) == 0) c = punct_x;
        else c = punct_set[$urandom_range(0, punct_set.len() - 1)];
        add(c, 1'b0);
      end else if (pick <= 10) begin
        add(CH_QUOTE, 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            add(CH_QUOTE, 1'b0);
            add(CH_QUOTE, 1'b0);
          end else begin
            c = 8'($urandom_range(1, 255));
            add((c == CH_QUOTE) ? 8'h51 : c, 1'b0);
          end
        end
        add(CH_QUOTE, 1'b0);
      end else if (pick == 11) begin
        add(CH_SLASH, 1'b0);
        add(CH_SLASH, 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) begin
          c = 8'($urandom_range(1, 255));
          add((c == CH_NEWLINE) ? 8'h2E : c, 1'b0);
        end
        add(CH_NEWLINE, 1'b0);
      end else if (pick == 12) begin
        add(CH_SLASH, 1'b0);
        add(CH_STAR, 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) begin
          c = $urandom_range(0, 2) == 0 ? CH_STAR : 8'($urandom_range(1, 255));
          add(c, 1'b0);
        end
        add(CH_STAR, 1'b0);
        add(CH_SLASH, 1'b0);
      end else if (pick <= 14) begin
        len = $urandom_range(1, 2);
        repeat (len) add(blank_byte(), 1'b0);
      end else if (pick <= 17) begin
        add(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick == 18) begin
        // string cut off by end of text
        add(CH_QUOTE, 1'b0);
        len = $urandom_range(0, 2);
        repeat (len) add(8'($urandom_range(1, 255)), 1'b0);
        add(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        add(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  task automatic send_all();
    int        gap, sent;
    text_row_t row;
    sent = 0;
    while (text_q.size() != 0) begin
      row = text_q.pop_front();
      if (sent % 16 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      gap = tx_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid    <= 1'b1;
      in_char     <= row.ch;
      end_of_text <= row.eot;
      cur_row     <= row;
      do @(posedge clk); while (in_stall);
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain(int extra);
    @(posedge clk);
    while (tok_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_punct(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    punct_x = v;
  endtask

  // result side: random stall per request, calm stretches, one long hold-off
  initial begin
    int n, taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 16 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  // prediction on accepted input, checking on accepted output, watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        lex_step(cur_row.ch, cur_row.eot);
        if (cur_row.n_fix < 0) begin
          foreach (step_q[i]) tok_q.insert(tok_q.size(), step_q[i]);
        end else begin
          if (cur_row.n_fix > 0) tok_q.insert(tok_q.size(), cur_row.r0);
          if (cur_row.n_fix > 1) tok_q.insert(tok_q.size(), cur_row.r1);
        end
      end
      if (out_valid && !out_stall) begin
        if (tok_q.size() == 0) begin
          report_bad("unexpected result_kind", result_kind, -1);
        end else begin
          want = tok_q.pop_front();
          if (result_kind !== want.kind) report_bad("result_kind", result_kind, want.kind);
          if (tok_char !== want.ch) report_bad("tok_char", tok_char, want.ch);
          if (token_last !== want.last) report_bad("token_last", token_last, want.last);
        end
        n_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no request moved for %0d cycles", quiet_cycles);
          $display("tb_text_token_splitter failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset punctuation byte, word flush, strings, numbers, comments, ends
    add_fix(8'h5A, 1'b1, 1, res(KIND_END, 8'h00, 1'b0), res(KIND_CHAR, 8'h00, 1'b0));
    add_fix(8'hA3, 1'b0, 1, res(KIND_CHAR, 8'hA3, 1'b1), res(KIND_CHAR, 8'h00, 1'b0));
    add_fix("a", 1'b0, 0, res(KIND_CHAR, 8'h00, 1'b0), res(KIND_CHAR, 8'h00, 1'b0));
    add_fix(8'hFF, 1'b0, 1, res(KIND_CHAR, "a", 1'b0), res(KIND_CHAR, 8'h00, 1'b0));
    add_fix(CH_SPACE, 1'b0, 1, res(KIND_CHAR, 8'hFF, 1'b1), res(KIND_CHAR, 8'h00, 1'b0));
    add(CH_QUOTE, 1'b0);
    add(CH_QUOTE, 1'b0);
    // closing quote followed directly by punctuation
    add_fix("(", 1'b0, 2, res(KIND_EMPTY, 8'h00, 1'b1), res(KIND_CHAR, "(", 1'b1));
    add(CH_QUOTE, 1'b0);
    add("x", 1'b0);
    add(CH_QUOTE, 1'b0);
    add(CH_QUOTE, 1'b0);
    add(CH_QUOTE, 1'b0);
    add(CH_MINUS, 1'b0);
    add("5", 1'b0);
    add(CH_SPACE, 1'b0);
    // slash, star, slash is a whole comment
    add(CH_SLASH, 1'b0);
    add(CH_STAR, 1'b0);
    add(CH_SLASH, 1'b0);
    add(CH_SLASH, 1'b0);
    add(CH_SLASH, 1'b0);
    add(CH_NEWLINE, 1'b0);
    add(CH_MINUS, 1'b0);
    add_fix(CH_NUL, 1'b0, 2, res(KIND_CHAR, CH_MINUS, 1'b1), res(KIND_END, 8'h00, 1'b0));
    add(CH_QUOTE, 1'b0);
    add("q", 1'b0);
    add_fix(8'hC3, 1'b1, 2, res(KIND_CHAR, "q", 1'b1), res(KIND_END, 8'h00, 1'b0));
    send_all();
    drain(8);

    hold_req = 1'b1;
    foreach (punct_cfgs[p]) begin
      write_punct(punct_cfgs[p]);
      gen_text(PHASE_ITEMS);
      send_all();
      drain(8);
    end
    drain(20);

    if (bad_count == 0) begin
      $display("tb_text_token_splitter passed");
    end else begin
      $display("tb_text_token_splitter failed");
    end
    $finish;
  end

endmodule
